### sv/ils_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed list store: sizes, request and status codes,
// and the control struct that the top level broadcasts to every cell.
// Has no dependencies.
package ils_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned PosW    = 8;
  localparam int unsigned CmpW    = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned OutCntW = 9;

  localparam logic [ReqW-1:0] REQ_APPEND = 2'd0;
  localparam logic [ReqW-1:0] REQ_READ   = 2'd1;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd2;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic             wr_en;
    logic             rm_en;
    logic             ld_en;
    logic             sh_en;
    logic [CntW-1:0]  count;
    logic [CntW-1:0]  pos;
    logic [DataW-1:0] value;
  } ils_ctl_t;

endpackage

### sv/ils_cell.sv
`timescale 1ns / 1ps
// One cell of the list chain: holds one entry and one stage of the read line.
// Depends on ils_pkg for sizes and the broadcast control struct.
module ils_cell
  import ils_pkg::*;
(
  input  logic             clk_i,
  input  logic [IdxW-1:0]  cell_idx_i,
  input  ils_ctl_t         ctl_i,
  input  logic [DataW-1:0] nbr_entry_i,
  input  logic [DataW-1:0] nbr_rd_i,
  output logic [DataW-1:0] entry_o,
  output logic [DataW-1:0] rd_o
);

  logic [DataW-1:0] entry_q, entry_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic [CntW-1:0]  idx;

  assign idx = CntW'(cell_idx_i);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.wr_en && (idx == ctl_i.count)) begin
      entry_d = ctl_i.value;
    end else if (ctl_i.rm_en && (idx >= ctl_i.pos) && ((idx + 1'b1) < ctl_i.count)) begin
      entry_d = nbr_entry_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctl_i.ld_en) begin
      rd_d = entry_q;
    end else if (ctl_i.sh_en) begin
      rd_d = nbr_rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

### sv/indexed_list_store_core.sv
`timescale 1ns / 1ps
// For append, remove, clear and out-of-range requests the result is registered
// and shows on the output the cycle after the item is taken.
// A read at position p loads the read line and shifts it p times toward
// cell 0, then registers its result once the output is free; no new item
// is taken until that read result has been loaded into the output.
module indexed_list_store_core
  import ils_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [DataW-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] read_value_o,
  output logic [StatW-1:0]        status_o,
  output logic [OutCntW-1:0]      entry_count_o
);

  // Reset clears the count, the controller and the output valid; entries are
  // not cleared. Depends on ils_pkg and ils_cell.

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SHIFT = 1'b1;

  logic             state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  remain_q, remain_d;
  logic             out_valid_q;
  logic [DataW-1:0] rv_q, rv_d;
  logic [StatW-1:0] st_q, st_d;
  logic [CntW-1:0]  oc_q;
  logic             load_out;
  logic             out_free;
  logic             in_acc;
  logic             in_range;
  ils_ctl_t         ctl;

  logic [DataW-1:0] entry_w [DEPTH+1];
  logic [DataW-1:0] rd_w    [DEPTH+1];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = CmpW'(position_i) < CmpW'(count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    remain_d  = remain_q;
    load_out  = 1'b0;
    rv_d      = '0;
    st_d      = STAT_DONE;
    ctl.wr_en = 1'b0;
    ctl.rm_en = 1'b0;
    ctl.ld_en = 1'b0;
    ctl.sh_en = 1'b0;
    ctl.count = count_q;
    ctl.pos   = CntW'(position_i);
    ctl.value = value_in_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_APPEND: begin
              load_out = 1'b1;
              if (count_q < CntW'(DEPTH)) begin
                ctl.wr_en = 1'b1;
                count_d   = count_q + 1'b1;
              end else begin
                st_d = STAT_FULL;
              end
            end
            REQ_READ: begin
              if (in_range) begin
                ctl.ld_en = 1'b1;
                remain_d  = IdxW'(position_i);
                state_d   = S_SHIFT;
              end else begin
                load_out = 1'b1;
                st_d     = STAT_RANGE;
              end
            end
            REQ_REMOVE: begin
              load_out = 1'b1;
              if (in_range) begin
                ctl.rm_en = 1'b1;
                count_d   = count_q - 1'b1;
              end else begin
                st_d = STAT_RANGE;
              end
            end
            REQ_CLEAR: begin
              load_out = 1'b1;
              count_d  = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (remain_q != '0) begin
          ctl.sh_en = 1'b1;
          remain_d  = remain_q - 1'b1;
        end else if (out_free) begin
          load_out = 1'b1;
          rv_d     = rd_w[0];
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign entry_w[DEPTH] = '0;
  assign rd_w[DEPTH]    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ils_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (IdxW'(i)),
      .ctl_i       (ctl),
      .nbr_entry_i (entry_w[i+1]),
      .nbr_rd_i    (rd_w[i+1]),
      .entry_o     (entry_w[i]),
      .rd_o        (rd_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rv_q <= rv_d;
      st_q <= st_d;
      oc_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rv_q;
  assign status_o      = st_q;
  assign entry_count_o = OutCntW'(oc_q);

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_store_core: a directed pass, then
// random append, read, remove and clear traffic with random idling and output stalls.
// A tracker class predicts every result. Depends on ils_pkg and the RTL.
module testbench;
  import ils_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] read_value;
    logic [StatW-1:0]        status;
    logic [OutCntW-1:0]      entry_count;
  } list_result_t;

  class list_store_tracker;
    logic signed [DataW-1:0] entries [DEPTH];
    int unsigned             count;
    list_result_t            pending_results [$];
    int unsigned             errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void note_request(input logic [ReqW-1:0] req, input logic [PosW-1:0] pos,
                               input logic signed [DataW-1:0] val);
      list_result_t res;
      int unsigned  idx;
      int unsigned  i;
      res.read_value = '0;
      res.status     = STAT_DONE;
      idx            = pos;
      case (req)
        REQ_APPEND: begin
          if (count < DEPTH) begin
            entries[count] = val;
            count++;
          end else begin
            res.status = STAT_FULL;
          end
        end
        REQ_READ: begin
          if (idx < count && idx < DEPTH) begin
            res.read_value = entries[idx];
          end else begin
            res.status = STAT_RANGE;
          end
        end
        REQ_REMOVE: begin
          if (idx < count && idx < DEPTH) begin
            for (i = idx; i + 1 < count; i++) begin
              entries[i] = entries[i + 1];
            end
            count--;
          end else begin
            res.status = STAT_RANGE;
          end
        end
        default: begin
          count = 0;
        end
      endcase
      res.entry_count = OutCntW'(count);
      pending_results.push_back(res);
    endfunction

    function void check_result(input logic signed [DataW-1:0] rv, input logic [StatW-1:0] st,
                               input logic [OutCntW-1:0] cnt);
      list_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: read_value %0d status %0d entry_count %0d",
                 $time, rv, st, cnt);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (rv !== exp_res.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, exp_res.read_value, rv);
        errors++;
      end
      if (st !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, st);
        errors++;
      end
      if (cnt !== exp_res.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, exp_res.entry_count, cnt);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [ReqW-1:0]         req_type_i = REQ_CLEAR;
  logic [PosW-1:0]         position_i = '0;
  logic signed [DataW-1:0] value_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] read_value_o;
  logic [StatW-1:0]        status_o;
  logic [OutCntW-1:0]      entry_count_o;

  list_store_tracker tracker = new();
  int unsigned       burst_left = 0;
  int unsigned       stall_mode = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_phase = 0;

  indexed_list_store_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .value_in_i    (value_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_phase % 8) >= 5);
    endcase
    stall_phase <= stall_phase + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(read_value_o, status_o, entry_count_o);
    end
  end

  task automatic send_req(input logic [ReqW-1:0] req, input logic [PosW-1:0] pos,
                          input logic signed [DataW-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_in_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(req, pos, val);
  endtask

  task automatic run_directed();
    send_req(REQ_CLEAR, 8'd0, 32'sd0);
    send_req(REQ_READ, 8'd0, 32'sd0);
    send_req(REQ_REMOVE, 8'd0, 32'sd0);
    send_req(REQ_APPEND, 8'd0, 32'sh7FFF_FFFF);
    send_req(REQ_READ, 8'd0, 32'sd0);
    send_req(REQ_REMOVE, 8'd0, 32'sd0);
    send_req(REQ_READ, 8'd0, 32'sd0);
    send_req(REQ_APPEND, 8'hFF, 32'sh8000_0000);
    send_req(REQ_APPEND, 8'd0, -32'sd1);
    send_req(REQ_APPEND, 8'd0, 32'sd0);
    send_req(REQ_APPEND, 8'd0, 32'sh5555_5555);
    send_req(REQ_READ, 8'd3, 32'sd0);
    send_req(REQ_READ, 8'd4, 32'sd0);
    send_req(REQ_READ, 8'hFF, -32'sd1);
    send_req(REQ_REMOVE, 8'd1, 32'sd0);
    send_req(REQ_READ, 8'd1, 32'sd0);
    send_req(REQ_REMOVE, 8'd3, 32'sd0);
    send_req(REQ_REMOVE, 8'd2, 32'sd0);
    send_req(REQ_READ, 8'd0, 32'sd0);
    send_req(REQ_CLEAR, 8'hFF, 32'shAAAA_AAAA);
    send_req(REQ_READ, 8'd0, 32'sd0);
  endtask

  // The first segment fills the list so that appends to a full store occur early.
  task automatic run_random(input int unsigned total);
    int unsigned      issued;
    int unsigned      seg_left;
    int unsigned      mode;
    int unsigned      roll;
    int unsigned      cnt;
    int unsigned      sel;
    logic [ReqW-1:0]  req;
    logic [PosW-1:0]  pos;
    issued   = 0;
    seg_left = 320;
    mode     = 0;
    while (issued < total) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 200);
        mode     = $urandom_range(0, 2);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0: req = (roll < 90) ? REQ_APPEND : REQ_READ;
        1: req = (roll < 60) ? REQ_REMOVE : (roll < 85) ? REQ_READ :
                 (roll < 98) ? REQ_APPEND : REQ_CLEAR;
        default: req = (roll < 35) ? REQ_APPEND : (roll < 66) ? REQ_READ :
                       (roll < 97) ? REQ_REMOVE : REQ_CLEAR;
      endcase
      cnt = tracker.count;
      sel = $urandom_range(0, 9);
      if (cnt > 0 && sel < 8) begin
        pos = PosW'($urandom_range(0, cnt - 1));
      end else if (sel == 8 && cnt < 256) begin
        pos = PosW'(cnt);
      end else begin
        pos = PosW'($urandom_range(0, 255));
      end
      send_req(req, pos, $urandom());
      issued++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(1350);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
